@@ rtl/ppc_pkg.sv @@
package ppc_pkg;

	// field and datapath widths
	localparam int TABLE_SIZE = 256;
	localparam int IDX_W      = 8;
	localparam int ROM_W      = 8;
	localparam int COL_W      = 9;
	localparam int ROW_W      = 8;
	localparam int TIME_W     = 8;
	localparam int COLOR_W    = 8;
	localparam int DIV_W      = 9;              // widest divisor (region width)
	localparam int DQ_W       = COL_W + ROM_W;  // widest dividend, column times sine
	localparam int REM_W      = DIV_W;
	localparam int CSUM_W     = ROM_W + 1;
	localparam int TOTAL_W    = ROM_W + 2;
	localparam int NUM_CELLS  = DQ_W;           // one quotient bit per cell

	// divide by three: x * 683 >> 11 is exact for x below 768
	localparam int RECIP_SHIFT = 11;
	localparam int PROD3_W     = TOTAL_W + RECIP_SHIFT - 1;
	localparam logic [PROD3_W-1:0] RECIP_3 = PROD3_W'(683);

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_REGION_WIDTH  = 1'b0,
		REG_REGION_HEIGHT = 1'b1
	} cfg_reg_t;

	localparam logic [COL_W-1:0] REGION_WIDTH_RST  = 9'd80;
	localparam logic [ROW_W-1:0] REGION_HEIGHT_RST = 8'd50;

	// one restoring step
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [DQ_W-1:0]  dq;
	} div_pair_t;

	// payload handed from cell to cell
	typedef struct packed {
		div_pair_t           col_div;
		div_pair_t           row_div;
		logic [CSUM_W-1:0]   csum;
		logic [TIME_W-1:0]   t;
	} cell_data_t;

	// sine table, built at elaboration in Q30 fixed point
	localparam int          Q_BITS      = 30;
	localparam logic [63:0] Q_ONE       = 64'd1 << Q_BITS;
	localparam logic [63:0] HALF_PI_Q   = 64'd1686629713;
	localparam logic [63:0] SINE_PERIOD = 64'd255;

	typedef logic [TABLE_SIZE-1:0][ROM_W-1:0] sine_table_t;

	function automatic logic [63:0] horner_sub(input logic [63:0] term);
		return (term > Q_ONE) ? 64'd0 : Q_ONE - term;
	endfunction

	// sin((pi/2) * m / 255), Taylor series in Horner form through x^17
	function automatic logic [63:0] quarter_sine(input logic [63:0] m);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] acc;
		x   = (HALF_PI_Q * m) / SINE_PERIOD;
		x2  = (x * x) >> Q_BITS;
		acc = Q_ONE;
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd272);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd210);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd156);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd110);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd72);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd42);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd20);
		acc = horner_sub(((x2 * acc) >> Q_BITS) / 64'd6);
		acc = (x * acc) >> Q_BITS;
		return (acc > Q_ONE) ? Q_ONE : acc;
	endfunction

	function automatic logic [ROM_W-1:0] rom_entry(input logic [63:0] i);
		logic [63:0] k;
		logic [63:0] q;
		logic [63:0] m;
		logic        neg;
		logic [63:0] s;
		logic [63:0] num;
		logic [63:0] v;
		k = i % SINE_PERIOD;
		q = 64'd4 * k;
		if (q <= SINE_PERIOD) begin
			m   = q;
			neg = 1'b0;
		end else if (q <= 64'd2 * SINE_PERIOD) begin
			m   = 64'd2 * SINE_PERIOD - q;
			neg = 1'b0;
		end else if (q <= 64'd3 * SINE_PERIOD) begin
			m   = q - 64'd2 * SINE_PERIOD;
			neg = 1'b1;
		end else begin
			m   = 64'd4 * SINE_PERIOD - q;
			neg = 1'b1;
		end
		s   = quarter_sine(m);
		num = neg ? 64'd255 * (Q_ONE - s) : 64'd255 * (Q_ONE + s);
		v   = num >> (Q_BITS + 1);
		return (v > 64'd255) ? 8'hff : v[ROM_W-1:0];
	endfunction

	function automatic sine_table_t build_sine_table();
		sine_table_t tbl;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl[i] = rom_entry(64'(i));
		end
		return tbl;
	endfunction

	localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

@@ rtl/ppc_pixel_if.sv @@
interface ppc_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [ppc_pkg::COL_W-1:0]   pixel_column;
	logic [ppc_pkg::ROW_W-1:0]   pixel_row;
	logic [ppc_pkg::TIME_W-1:0]  frame_time;

	modport source (output valid, output pixel_column, output pixel_row,
		output frame_time, input ready);
	modport sink (input valid, input pixel_column, input pixel_row,
		input frame_time, output ready);
endinterface

@@ rtl/ppc_color_if.sv @@
interface ppc_color_if;
	logic                        valid;
	logic                        ready;
	logic [ppc_pkg::COLOR_W-1:0] pixel_color;

	modport source (output valid, output pixel_color, input ready);
	modport sink (input valid, input pixel_color, output ready);
endinterface

@@ rtl/ppc_div_cell.sv @@
module ppc_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  ppc_pkg::cell_data_t         in_data,
	input  logic [ppc_pkg::DIV_W-1:0]   col_divisor,
	input  logic [ppc_pkg::DIV_W-1:0]   row_divisor,
	input  logic                        next_load,
	output logic                        load,
	output logic                        out_valid,
	output ppc_pkg::cell_data_t         out_data
);

	logic                valid_q;
	ppc_pkg::cell_data_t data_q;
	ppc_pkg::cell_data_t data_next;

	// shift one dividend bit into the remainder, subtract when it fits
	function automatic ppc_pkg::div_pair_t div_step(input ppc_pkg::div_pair_t cur,
			input logic [ppc_pkg::DIV_W-1:0] divisor);
		logic [ppc_pkg::REM_W:0] shifted;
		logic                    fits;
		ppc_pkg::div_pair_t      nxt;
		shifted  = {cur.rem, cur.dq[ppc_pkg::DQ_W-1]};
		fits     = (shifted >= {1'b0, divisor});
		nxt.rem  = fits ? ppc_pkg::REM_W'(shifted - {1'b0, divisor})
			: shifted[ppc_pkg::REM_W-1:0];
		nxt.dq   = {cur.dq[ppc_pkg::DQ_W-2:0], fits};
		return nxt;
	endfunction

	always_comb begin
		data_next         = in_data;
		data_next.col_div = div_step(in_data.col_div, col_divisor);
		data_next.row_div = div_step(in_data.row_div, row_divisor);
	end

	assign load = !valid_q || next_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= data_next;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

@@ rtl/plasma_pixel_color.sv @@
// plasma_pixel_color: one 8-bit plasma color per pixel beat
// a beat is registered through stage 1, stage 2, the cells, stage 3 and output
// throughput: one pixel per cycle unless stalled; depth set by the 17-cell chain
// stalls ripple back stage by stage, empty stages fill while the output waits
// reset (arst_n low) empties every stage and loads region width 80 and height 50
module plasma_pixel_color (
	input  logic                          clk,
	input  logic                          arst_n,
	ppc_pixel_if.sink                     pixel,
	ppc_color_if.source                   color,
	input  logic                          cfg_we,
	input  logic [ppc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [ppc_pkg::COL_W-1:0] region_width_q;
	logic [ppc_pkg::ROW_W-1:0] region_height_q;
	logic [ppc_pkg::DIV_W-1:0] col_divisor;
	logic [ppc_pkg::DIV_W-1:0] row_divisor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_width_q  <= ppc_pkg::REGION_WIDTH_RST;
			region_height_q <= ppc_pkg::REGION_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ppc_pkg::REG_REGION_WIDTH: begin
					region_width_q <= cfg_data[ppc_pkg::COL_W-1:0];
				end
				ppc_pkg::REG_REGION_HEIGHT: begin
					region_height_q <= cfg_data[ppc_pkg::ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a zero divisor divides as one
	assign col_divisor = (region_width_q == '0) ? ppc_pkg::DIV_W'(1) : region_width_q;
	assign row_divisor = (region_height_q == '0) ? ppc_pkg::DIV_W'(1)
		: {1'b0, region_height_q};

	// load enables, from the output back to the input
	logic load_s1;
	logic load_s2;
	logic load_s3;
	logic load_out;

	logic link_valid [ppc_pkg::NUM_CELLS+1];
	logic link_load  [ppc_pkg::NUM_CELLS+1];
	ppc_pkg::cell_data_t link_data [ppc_pkg::NUM_CELLS+1];

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;

	assign load_out = !out_valid_q || color.ready;
	assign load_s3  = !valid_s3 || load_out;
	assign link_load[ppc_pkg::NUM_CELLS] = load_s3;
	assign load_s2  = !valid_s2 || link_load[0];
	assign load_s1  = !valid_s1 || load_s2;
	assign pixel.ready = load_s1;

	// stage 1: rom indices from the beat, four table reads
	// all indices wrap at 256, so only the low byte of each term matters
	logic [ppc_pkg::IDX_W-1:0] col8;
	logic [ppc_pkg::IDX_W-1:0] tm;
	logic [ppc_pkg::IDX_W-1:0] row_t;
	logic [ppc_pkg::IDX_W-1:0] idx_c1;
	logic [ppc_pkg::IDX_W-1:0] idx_c3;
	logic [ppc_pkg::IDX_W-1:0] idx_v1;
	logic [ppc_pkg::IDX_W-1:0] idx_v2;

	assign col8   = pixel.pixel_column[ppc_pkg::IDX_W-1:0];
	assign tm     = pixel.frame_time;
	assign row_t  = pixel.pixel_row + tm;
	// 3*col + 2*t
	assign idx_c1 = col8 + {col8[ppc_pkg::IDX_W-2:0], 1'b0} + {tm[ppc_pkg::IDX_W-2:0], 1'b0};
	// 3*(row + t)
	assign idx_c3 = row_t + {row_t[ppc_pkg::IDX_W-2:0], 1'b0};
	// 3*t
	assign idx_v1 = tm + {tm[ppc_pkg::IDX_W-2:0], 1'b0};
	// quarter-turn offset plus 5*t
	assign idx_v2 = 8'd64 + tm + {tm[ppc_pkg::IDX_W-3:0], 2'b00};

	logic [ppc_pkg::ROM_W-1:0]  c1_s1;
	logic [ppc_pkg::ROM_W-1:0]  c3_s1;
	logic [ppc_pkg::ROM_W-1:0]  v1_s1;
	logic [ppc_pkg::ROM_W-1:0]  v2_s1;
	logic [ppc_pkg::COL_W-1:0]  col_s1;
	logic [ppc_pkg::ROW_W-1:0]  row_s1;
	logic [ppc_pkg::TIME_W-1:0] t_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			c1_s1  <= ppc_pkg::SINE_TABLE[idx_c1];
			c3_s1  <= ppc_pkg::SINE_TABLE[idx_c3];
			v1_s1  <= ppc_pkg::SINE_TABLE[idx_v1];
			v2_s1  <= ppc_pkg::SINE_TABLE[idx_v2];
			col_s1 <= pixel.pixel_column;
			row_s1 <= pixel.pixel_row;
			t_s1   <= pixel.frame_time;
		end
	end

	// stage 2: the two dividends, partial color sum, loaded into the divider format
	logic [ppc_pkg::DQ_W-1:0]   prod_col;
	logic [ppc_pkg::DQ_W-1:0]   prod_row;
	ppc_pkg::cell_data_t        front_data;
	ppc_pkg::cell_data_t        data_s2;

	assign prod_col = {{(ppc_pkg::DQ_W-ppc_pkg::COL_W){1'b0}}, col_s1}
		* {{(ppc_pkg::DQ_W-ppc_pkg::ROM_W){1'b0}}, v1_s1};
	assign prod_row = {{(ppc_pkg::DQ_W-ppc_pkg::ROW_W){1'b0}}, row_s1}
		* {{(ppc_pkg::DQ_W-ppc_pkg::ROM_W){1'b0}}, v2_s1};

	always_comb begin
		front_data.col_div.rem = '0;
		front_data.col_div.dq  = prod_col;
		front_data.row_div.rem = '0;
		front_data.row_div.dq  = prod_row;
		front_data.csum        = {1'b0, c1_s1} + {1'b0, c3_s1};
		front_data.t           = t_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			data_s2 <= front_data;
		end
	end

	assign link_valid[0] = valid_s2;
	assign link_data[0]  = data_s2;

	// divider chain: each cell retires one quotient bit of both divisions
	for (genvar k = 0; k < ppc_pkg::NUM_CELLS; k++) begin : g_cell
		ppc_div_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.in_valid    (link_valid[k]),
			.in_data     (link_data[k]),
			.col_divisor (col_divisor),
			.row_divisor (row_divisor),
			.next_load   (link_load[k+1]),
			.load        (link_load[k]),
			.out_valid   (link_valid[k+1]),
			.out_data    (link_data[k+1])
		);
	end

	// stage 3: third color lookup, indexed by both quotients plus time
	ppc_pkg::cell_data_t       tail;
	logic [ppc_pkg::IDX_W-1:0] idx_c2;
	logic [ppc_pkg::ROM_W-1:0] c2_s3;
	logic [ppc_pkg::CSUM_W-1:0] csum_s3;

	assign tail   = link_data[ppc_pkg::NUM_CELLS];
	assign idx_c2 = tail.col_div.dq[ppc_pkg::IDX_W-1:0]
		+ tail.row_div.dq[ppc_pkg::IDX_W-1:0] + tail.t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (load_s3) begin
			valid_s3 <= link_valid[ppc_pkg::NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			c2_s3   <= ppc_pkg::SINE_TABLE[idx_c2];
			csum_s3 <= tail.csum;
		end
	end

	// output register: average of the three lookups, divide by three via reciprocal
	logic [ppc_pkg::TOTAL_W-1:0] total;
	logic [ppc_pkg::PROD3_W-1:0] prod3;
	logic [ppc_pkg::COLOR_W-1:0] color_q;

	assign total = {1'b0, csum_s3} + {2'b00, c2_s3};
	assign prod3 = {{(ppc_pkg::PROD3_W-ppc_pkg::TOTAL_W){1'b0}}, total} * ppc_pkg::RECIP_3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			color_q <= prod3[ppc_pkg::RECIP_SHIFT +: ppc_pkg::COLOR_W];
		end
	end

	assign color.valid       = out_valid_q;
	assign color.pixel_color = color_q;

endmodule
